[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on rising edge, async reset low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/hlpe_pkg.sv]
// ----------------------------------------------------------------------------
// hlpe_pkg
// Types and constants of the LED pulse encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hlpe_pkg;

	localparam int DURATION_WIDTH_DEF = 15;
	localparam int PULSES             = 24;
	localparam int CFG_IDX_W          = 4;

	localparam int ZERO_HIGH_RST = 14;
	localparam int ZERO_LOW_RST  = 40;
	localparam int ONE_HIGH_RST  = 40;
	localparam int ONE_LOW_RST   = 14;

	localparam logic [8:0] HUE_WRAP = 9'd360;
	localparam logic [6:0] PCT_MAX  = 7'd100;

	// floor(x/100) = (x*RECIP_100) >> 19 for x <= 25500
	localparam int RECIP_100       = 5243;
	localparam int RECIP_100_SHIFT = 19;
	// floor(x/60) = (x*RECIP_60) >> 20 for x <= 15045
	localparam int RECIP_60        = 17477;
	localparam int RECIP_60_SHIFT  = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH = 4'd0,
		REG_ZERO_LOW  = 4'd1,
		REG_ONE_HIGH  = 4'd2,
		REG_ONE_LOW   = 4'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_RGB = 1'b0,
		KIND_HSV = 1'b1
	} kind_t;

	// hue sectors, named by the max channel and the moving one
	typedef enum logic [2:0] {
		SEC_R_G = 3'd0,
		SEC_G_R = 3'd1,
		SEC_G_B = 3'd2,
		SEC_B_G = 3'd3,
		SEC_B_R = 3'd4,
		SEC_R_B = 3'd5
	} sector_t;

	// pixel record carried down the conversion pipeline
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [8:0]  hue;
		logic [6:0]  inv_sat;
		logic [6:0]  val;
		logic [7:0]  hmax;
		sector_t     sector;
		logic [5:0]  frac;
		logic [14:0] prod;
		logic [7:0]  hmin;
		logic [13:0] prod2;
		logic [7:0]  adj;
	} pipe_t;

endpackage

[design/hlpe_hsv.sv]
// ----------------------------------------------------------------------------
// hlpe_hsv
// Seven-stage color pipeline: HSV to RGB (raw RGB passes through), packs the GRB word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlpe_hsv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  hlpe_pkg::kind_t     kind,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [8:0]          hue,
	input  logic [6:0]          saturation,
	input  logic [6:0]          brightness,
	output logic                pix_valid,
	input  logic                pix_ready,
	output logic [23:0]         pix_word
);
	import hlpe_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic go_s1, go_s2, go_s3, go_s4, go_s5, go_s6, go_s7;
	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6;
	logic [23:0] word_s7;
	pipe_t d1, d2, d3, d4, d5, d6;
	logic [23:0] d7;

	logic [6:0]  sat_c;
	logic [14:0] v255;
	logic [27:0] q100a;
	logic [27:0] q100b;
	logic [7:0]  diff;
	logic [28:0] q60;
	logic [7:0]  hi, lo_adj;
	logic [7:0]  r, g, b;

	// stall chain
	always_comb begin
		go_s7 = !valid_s7 || pix_ready;
		go_s6 = !valid_s6 || go_s7;
		go_s5 = !valid_s5 || go_s6;
		go_s4 = !valid_s4 || go_s5;
		go_s3 = !valid_s3 || go_s4;
		go_s2 = !valid_s2 || go_s3;
		go_s1 = !valid_s1 || go_s2;
	end

	assign s_ready   = go_s1;
	assign pix_valid = valid_s7;
	assign pix_word  = word_s7;

	// s1: hue wrap, clamps
	always_comb begin
		d1 = '0;
		d1.kind  = kind;
		d1.red   = red;
		d1.green = green;
		d1.blue  = blue;
		d1.hue   = (hue >= HUE_WRAP) ? (hue - HUE_WRAP) : hue;
		sat_c    = (saturation > PCT_MAX) ? PCT_MAX : saturation;
		d1.inv_sat = PCT_MAX - sat_c;
		d1.val   = (brightness > PCT_MAX) ? PCT_MAX : brightness;
	end

	// s2: max = v*255/100, sector and offset within it
	always_comb begin
		d2 = p_s1;
		v255 = {p_s1.val, 8'd0} - {8'd0, p_s1.val};
		q100a = 28'(v255) * 28'(RECIP_100);
		d2.hmax = q100a[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
		if (p_s1.hue >= 9'd300) begin
			d2.sector = SEC_R_B;
			d2.frac   = 6'(p_s1.hue - 9'd300);
		end else if (p_s1.hue >= 9'd240) begin
			d2.sector = SEC_B_R;
			d2.frac   = 6'(p_s1.hue - 9'd240);
		end else if (p_s1.hue >= 9'd180) begin
			d2.sector = SEC_B_G;
			d2.frac   = 6'(p_s1.hue - 9'd180);
		end else if (p_s1.hue >= 9'd120) begin
			d2.sector = SEC_G_B;
			d2.frac   = 6'(p_s1.hue - 9'd120);
		end else if (p_s1.hue >= 9'd60) begin
			d2.sector = SEC_G_R;
			d2.frac   = 6'(p_s1.hue - 9'd60);
		end else begin
			d2.sector = SEC_R_G;
			d2.frac   = p_s1.hue[5:0];
		end
	end

	// s3: max*(100-s)
	always_comb begin
		d3 = p_s2;
		d3.prod = 15'(p_s2.hmax * p_s2.inv_sat);
	end

	// s4: min = prod/100
	always_comb begin
		d4 = p_s3;
		q100b = 28'(p_s3.prod) * 28'(RECIP_100);
		d4.hmin = q100b[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
	end

	// s5: (max-min)*frac
	always_comb begin
		d5 = p_s4;
		diff = p_s4.hmax - p_s4.hmin;
		d5.prod2 = 14'(diff * p_s4.frac);
	end

	// s6: adj = prod2/60
	always_comb begin
		d6 = p_s5;
		q60 = 29'(p_s5.prod2) * 29'(RECIP_60);
		d6.adj = q60[RECIP_60_SHIFT+7:RECIP_60_SHIFT];
	end

	// s7: sector select, GRB packing
	always_comb begin
		hi     = p_s6.hmin + p_s6.adj;
		lo_adj = p_s6.hmax - p_s6.adj;
		case (p_s6.sector)
			SEC_R_G: begin r = p_s6.hmax; g = hi;        b = p_s6.hmin; end
			SEC_G_R: begin r = lo_adj;    g = p_s6.hmax; b = p_s6.hmin; end
			SEC_G_B: begin r = p_s6.hmin; g = p_s6.hmax; b = hi;        end
			SEC_B_G: begin r = p_s6.hmin; g = lo_adj;    b = p_s6.hmax; end
			SEC_B_R: begin r = hi;        g = p_s6.hmin; b = p_s6.hmax; end
			default: begin r = p_s6.hmax; g = p_s6.hmin; b = lo_adj;    end
		endcase
		if (p_s6.kind == KIND_HSV) begin
			d7 = {g, r, b};
		end else begin
			d7 = {p_s6.green, p_s6.red, p_s6.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (go_s1) valid_s1 <= s_valid;
			if (go_s2) valid_s2 <= valid_s1;
			if (go_s3) valid_s3 <= valid_s2;
			if (go_s4) valid_s4 <= valid_s3;
			if (go_s5) valid_s5 <= valid_s4;
			if (go_s6) valid_s6 <= valid_s5;
			if (go_s7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && s_valid)  p_s1    <= d1;
		if (go_s2 && valid_s1) p_s2    <= d2;
		if (go_s3 && valid_s2) p_s3    <= d3;
		if (go_s4 && valid_s3) p_s4    <= d4;
		if (go_s5 && valid_s4) p_s5    <= d5;
		if (go_s6 && valid_s5) p_s6    <= d6;
		if (go_s7 && valid_s6) word_s7 <= d7;
	end

endmodule

[design/hlpe_ser.sv]
// ----------------------------------------------------------------------------
// hlpe_ser
// Pulse serializer: one GRB word in, 24 pulse words out, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlpe_ser #(
	parameter  int DW    = hlpe_pkg::DURATION_WIDTH_DEF,
	localparam int OUT_W = ((2 * DW + 1 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  logic [23:0]       pix_word,
	input  logic [DW-1:0]     zero_high,
	input  logic [DW-1:0]     zero_low,
	input  logic [DW-1:0]     one_high,
	input  logic [DW-1:0]     one_low,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // high_ticks, low_ticks, data_bit
	output logic              m_tlast
);
	import hlpe_pkg::*;

	localparam int CNT_W = $clog2(PULSES);

	logic [23:0]      word_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             last_beat;
	logic             bit_c;
	logic [DW-1:0]    high_c, low_c;

	assign last_beat = (cnt_q == CNT_W'(PULSES - 1));
	// next pixel loads on the same edge the last pulse word leaves
	assign pix_ready = !busy_q || (m_tready && last_beat);

	assign bit_c  = word_q[23];
	assign high_c = bit_c ? one_high : zero_high;
	assign low_c  = bit_c ? one_low : zero_low;

	assign m_tvalid = busy_q;
	assign m_tlast  = last_beat;
	assign m_tdata  = OUT_W'({bit_c, low_c, high_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pix_valid && pix_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			word_q <= pix_word;
		end else if (busy_q && m_tready) begin
			word_q <= {word_q[22:0], 1'b0};
		end
	end

endmodule

[design/hsv_led_pulse_encoder.sv]
// ----------------------------------------------------------------------------
// hsv_led_pulse_encoder
// Pixel color (raw RGB or HSV) to 24 one-wire LED bit pulse words.
// ----------------------------------------------------------------------------
// Each accepted pixel yields 24 pulse words, green, red, blue, MSB first, the
// last one flagged by m_tlast. The serializer emits one pulse word per cycle
// while m_tready is high and loads the next pixel as the last word leaves. A
// pixel passes the seven-stage color pipeline before its first pulse word
// shows; pipeline and serializer hold up to eight pixels, so input is taken
// while pulses of earlier pixels stream out. The user must write duration
// registers through the cfg port only while the block is idle; not enforced.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_led_pulse_encoder #(
	parameter  int DURATION_WIDTH = hlpe_pkg::DURATION_WIDTH_DEF,
	localparam int OUT_W = ((2 * DURATION_WIDTH + 1 + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// red, green, blue, hue, saturation, brightness
	input  logic [47:0]                    s_tdata,
	// kind
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// high_ticks, low_ticks, data_bit
	output logic [OUT_W-1:0]               m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_wr_en,
	input  logic [hlpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DURATION_WIDTH-1:0]      cfg_wr_data
);
	import hlpe_pkg::*;

	localparam int DW = DURATION_WIDTH;

	logic [DW-1:0] zero_high_q, zero_low_q, one_high_q, one_low_q;
	logic          pix_valid, pix_ready;
	logic [23:0]   pix_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= DW'(ZERO_HIGH_RST);
			zero_low_q  <= DW'(ZERO_LOW_RST);
			one_high_q  <= DW'(ONE_HIGH_RST);
			one_low_q   <= DW'(ONE_LOW_RST);
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_ZERO_HIGH: zero_high_q <= cfg_wr_data;
				REG_ZERO_LOW:  zero_low_q  <= cfg_wr_data;
				REG_ONE_HIGH:  one_high_q  <= cfg_wr_data;
				REG_ONE_LOW:   one_low_q   <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	hlpe_hsv u_hsv (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_tvalid),
		.s_ready    (s_tready),
		.kind       (kind_t'(s_tuser[0])),
		.red        (s_tdata[7:0]),
		.green      (s_tdata[15:8]),
		.blue       (s_tdata[23:16]),
		.hue        (s_tdata[32:24]),
		.saturation (s_tdata[39:33]),
		.brightness (s_tdata[46:40]),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_word   (pix_word)
	);

	hlpe_ser #(
		.DW (DW)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word),
		.zero_high (zero_high_q),
		.zero_low  (zero_low_q),
		.one_high  (one_high_q),
		.one_low   (one_low_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// a pixel never ends early: words keep coming until the flagged one
	`ASSERT_NEXT(a_no_early_end, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)
	// high durations follow the encoded bit
	`ASSERT_IMPL(a_high_match, clk, arst_n, m_tvalid, m_tdata[DW-1:0] == (m_tdata[2*DW] ? one_high_q : zero_high_q))
	// a stalled color word holds until the serializer takes it
	`ASSERT_NEXT(a_pix_hold, clk, arst_n, pix_valid && !pix_ready, pix_valid && $stable(pix_word))

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Pixel stream test of hsv_led_pulse_encoder: raw and HSV colors go in on the
// slave stream, every pulse word out is checked against a local GRB predictor
// under several duration settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import hlpe_pkg::*;

	localparam int DW         = DURATION_WIDTH_DEF;
	localparam int OUT_W      = ((2 * DW + 1 + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 400000;
	localparam int TAIL_WAIT  = 40;

	typedef struct {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [8:0]  hue;
		logic [6:0]  sat;
		logic [6:0]  bright;
	} pixel_t;

	typedef struct {
		logic [DW-1:0] high_ticks;
		logic [DW-1:0] low_ticks;
		logic          data_bit;
		logic          last;
	} pulse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_wr_data = '0;

	hsv_led_pulse_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pixel_t pixel_q[$];
	pulse_t pulse_q[$];
	logic [DW-1:0] dur_ticks[4];
	int pixels_queued = 0;
	int pixels_taken = 0;
	int errors = 0;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic in_accept = 1'b0;

	// expected 24-bit word, green in the top byte
	function automatic logic [23:0] grb_of_pixel(pixel_t p);
		int unsigned h, s, v, hmax, hmin, frac, adj, hi;
		int unsigned r, g, b;
		if (p.kind == KIND_RGB) begin
			return {p.green, p.red, p.blue};
		end
		h = p.hue % 360;
		s = (p.sat > 100) ? 100 : p.sat;
		v = (p.bright > 100) ? 100 : p.bright;
		hmax = (v * 255) / 100;
		hmin = (hmax * (100 - s)) / 100;
		frac = h % 60;
		adj = ((hmax - hmin) * frac) / 60;
		hi = hmin + adj;
		case (h / 60)
			0: begin r = hmax;       g = hi;         b = hmin;       end
			1: begin r = hmax - adj; g = hmax;       b = hmin;       end
			2: begin r = hmin;       g = hmax;       b = hi;         end
			3: begin r = hmin;       g = hmax - adj; b = hmax;       end
			4: begin r = hi;         g = hmin;       b = hmax;       end
			default: begin r = hmax; g = hmin;       b = hmax - adj; end
		endcase
		return {g[7:0], r[7:0], b[7:0]};
	endfunction

	task automatic flag_mismatch(string what, int unsigned exp_v, int unsigned got_v);
		$display("MISMATCH @%0d: %s expected %0d got %0d", cycles, what, exp_v, got_v);
		errors++;
	endtask

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		pixel_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || in_accept) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					p = pixel_q.pop_front();
					s_tdata <= {1'b0, p.bright, p.sat, p.hue, p.blue, p.green, p.red};
					s_tuser <= p.kind;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// monitor and predictor: everything sampled on the rising edge
	always @(posedge clk) begin
		pixel_t p;
		pulse_t e;
		logic [23:0] grb;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
		in_accept <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ZERO_HIGH: dur_ticks[REG_ZERO_HIGH] = cfg_wr_data;
					REG_ZERO_LOW:  dur_ticks[REG_ZERO_LOW]  = cfg_wr_data;
					REG_ONE_HIGH:  dur_ticks[REG_ONE_HIGH]  = cfg_wr_data;
					REG_ONE_LOW:   dur_ticks[REG_ONE_LOW]   = cfg_wr_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				p.kind   = kind_t'(s_tuser[0]);
				p.red    = s_tdata[7:0];
				p.green  = s_tdata[15:8];
				p.blue   = s_tdata[23:16];
				p.hue    = s_tdata[32:24];
				p.sat    = s_tdata[39:33];
				p.bright = s_tdata[46:40];
				grb = grb_of_pixel(p);
				for (int k = 0; k < PULSES; k++) begin
					e.data_bit   = grb[23-k];
					e.high_ticks = e.data_bit ? dur_ticks[REG_ONE_HIGH] : dur_ticks[REG_ZERO_HIGH];
					e.low_ticks  = e.data_bit ? dur_ticks[REG_ONE_LOW] : dur_ticks[REG_ZERO_LOW];
					e.last       = (k == PULSES - 1);
					pulse_q.push_back(e);
				end
				pixels_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (pulse_q.size() == 0) begin
					flag_mismatch("unexpected pulse word, pending", 0, 1);
				end else begin
					e = pulse_q.pop_front();
					if (m_tdata[DW-1:0] !== e.high_ticks)
						flag_mismatch("high_ticks", e.high_ticks, m_tdata[DW-1:0]);
					if (m_tdata[2*DW-1:DW] !== e.low_ticks)
						flag_mismatch("low_ticks", e.low_ticks, m_tdata[2*DW-1:DW]);
					if (m_tdata[2*DW] !== e.data_bit)
						flag_mismatch("data_bit", e.data_bit, m_tdata[2*DW]);
					if (m_tlast !== e.last)
						flag_mismatch("last", e.last, m_tlast);
				end
			end
		end
	end

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.kind  = kind_t'($urandom_range(1));
		p.red   = 8'($urandom_range(255));
		p.green = 8'($urandom_range(255));
		p.blue  = 8'($urandom_range(255));
		// mostly legal hue, some in the wrap region
		p.hue = ($urandom_range(9) < 7) ? 9'($urandom_range(359)) : 9'($urandom_range(511));
		case ($urandom_range(7))
			0: p.sat = 7'd100;
			1: p.sat = 7'd0;
			default: p.sat = 7'($urandom_range(127));
		endcase
		case ($urandom_range(7))
			0: p.bright = 7'd100;
			1: p.bright = 7'd0;
			default: p.bright = 7'($urandom_range(127));
		endcase
		return p;
	endfunction

	task automatic queue_pixel(kind_t k, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [8:0] h, logic [6:0] s, logic [6:0] v);
		pixel_t p;
		p.kind = k; p.red = r; p.green = g; p.blue = b;
		p.hue = h; p.sat = s; p.bright = v;
		pixel_q.push_back(p);
		pixels_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
		cfg_index <= idx;
		cfg_wr_data <= val;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
	endtask

	task automatic set_durations(logic [DW-1:0] zh, logic [DW-1:0] zl,
			logic [DW-1:0] oh, logic [DW-1:0] ol);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_ZERO_LOW, zl);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_ONE_LOW, ol);
	endtask

	// wait until every queued pixel is in and every pulse word is out
	task automatic wait_drained();
		while (pixels_taken != pixels_queued || pulse_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(int n, int src_pct, int sink_pct);
		pixel_t p;
		cfg_wr_en <= 1'b0;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < n; i++) begin
			p = random_pixel();
			pixel_q.push_back(p);
			pixels_queued++;
		end
		wait_drained();
	endtask

	initial begin
		dur_ticks[REG_ZERO_HIGH] = DW'(ZERO_HIGH_RST);
		dur_ticks[REG_ZERO_LOW]  = DW'(ZERO_LOW_RST);
		dur_ticks[REG_ONE_HIGH]  = DW'(ONE_HIGH_RST);
		dur_ticks[REG_ONE_LOW]   = DW'(ONE_LOW_RST);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed colors at reset durations, no idling
		queue_pixel(KIND_RGB, 8'h00, 8'h00, 8'h00, 9'd511, 7'd127, 7'd127);
		queue_pixel(KIND_RGB, 8'hFF, 8'hFF, 8'hFF, 9'd0, 7'd0, 7'd0);
		queue_pixel(KIND_RGB, 8'hAA, 8'h55, 8'h0F, 9'd0, 7'd0, 7'd0);
		queue_pixel(KIND_RGB, 8'hFF, 8'h00, 8'h00, 9'd0, 7'd0, 7'd0);
		queue_pixel(KIND_RGB, 8'h00, 8'hFF, 8'h00, 9'd0, 7'd0, 7'd0);
		queue_pixel(KIND_RGB, 8'h00, 8'h00, 8'h81, 9'd0, 7'd0, 7'd0);
		queue_pixel(KIND_HSV, 8'hFF, 8'hFF, 8'hFF, 9'd0, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd59, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd60, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd119, 7'd80, 7'd90);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd120, 7'd50, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd180, 7'd100, 7'd50);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd240, 7'd33, 7'd77);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd300, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd359, 7'd100, 7'd100);
		// hue wrap, saturation and value clamps
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd360, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd400, 7'd100, 7'd100);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd511, 7'd127, 7'd127);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd200, 7'd0, 7'd127);
		queue_pixel(KIND_HSV, 8'h00, 8'h00, 8'h00, 9'd45, 7'd101, 7'd0);
		queue_pixel(KIND_HSV, 8'hFF, 8'hFF, 8'hFF, 9'd330, 7'd127, 7'd101);
		wait_drained();

		// all-zero durations; writes to unmapped indexes must not land
		set_durations('0, '0, '0, '0);
		write_reg(CFG_IDX_W'(REG_ONE_LOW + 1 + $urandom_range(11)), {DW{1'b1}});
		write_reg({CFG_IDX_W{1'b1}}, {DW{1'b1}});
		run_random(60, 0, 0);

		set_durations({DW{1'b1}}, {DW{1'b1}}, {DW{1'b1}}, {DW{1'b1}});
		run_random(60, 80, 0);

		set_durations(DW'($urandom), DW'($urandom), DW'($urandom), DW'($urandom));
		run_random(60, 0, 80);

		set_durations(DW'($urandom), {DW{1'b1}}, '0, DW'($urandom));
		run_random(60, 17, 17);

		set_durations(DW'(ZERO_HIGH_RST), DW'(ZERO_LOW_RST), DW'(ONE_HIGH_RST),
			DW'(ONE_LOW_RST));
		run_random(60, 0, 0);

		repeat (TAIL_WAIT) @(negedge clk);
		if (pulse_q.size() != 0)
			flag_mismatch("pulse words never seen", 0, pulse_q.size());
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
